>>> rtl/axis_angle_rotation_matrix_macros.svh
// Assertion macros for the axis-angle rotation matrix block.
// No dependencies.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_MACROS_SVH

// Implication checked on every edge outside reset.
`define AAR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on every edge, reset included.
`define AAR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/aar_pkg.sv
// Package for the axis-angle rotation matrix block: constants, CORDIC table, types.
// No dependencies.
package aar_pkg;

  localparam int CordicStagesDef = 16;
  localparam int FracBitsDef     = 14;
  localparam int TableLen        = 24;
  localparam int CordicFrac      = 30;
  localparam int CordicW         = 34;
  localparam int AngleW          = 32;
  localparam int FieldW          = 16;
  localparam logic signed [CordicW-1:0] InvGain = 34'sd652032875;

  typedef logic signed [FieldW-1:0] field_t;

  typedef struct packed {
    field_t axis_x;
    field_t axis_y;
    field_t axis_z;
    logic [FieldW-1:0] angle;
  } req_t;

  typedef struct packed {
    field_t m11; field_t m12; field_t m13;
    field_t m21; field_t m22; field_t m23;
    field_t m31; field_t m32; field_t m33;
  } mat_t;

  function automatic logic signed [AngleW:0] atan_turn(input int idx);
    logic signed [AngleW:0] t;
    begin
      case (idx)
        0:  t = 33'sh020000000;
        1:  t = 33'sh012E4051E;
        2:  t = 33'sh009FB385B;
        3:  t = 33'sh0051111D4;
        4:  t = 33'sh0028B0D43;
        5:  t = 33'sh00145D7E1;
        6:  t = 33'sh000A2F61E;
        7:  t = 33'sh000517C55;
        8:  t = 33'sh00028BE53;
        9:  t = 33'sh000145F2F;
        10: t = 33'sh0000A2F98;
        11: t = 33'sh0000517CC;
        12: t = 33'sh000028BE6;
        13: t = 33'sh0000145F3;
        14: t = 33'sh00000A2FA;
        15: t = 33'sh00000517D;
        16: t = 33'sh0000028BE;
        17: t = 33'sh00000145F;
        18: t = 33'sh000000A30;
        19: t = 33'sh000000518;
        20: t = 33'sh00000028C;
        21: t = 33'sh000000146;
        22: t = 33'sh0000000A3;
        23: t = 33'sh000000051;
        default: t = '0;
      endcase
      return t;
    end
  endfunction

endpackage

>>> rtl/aar_stream_if.sv
// Valid/ready channel carrying one payload of type T.
// No dependencies; the payload type is a parameter.
interface aar_stream_if #(parameter type T = logic) (input logic clk_i);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/aar_cordic.sv
// Unrolled rotation-mode CORDIC, one register stage per iteration, with sideband.
// Depends on aar_pkg.
module aar_cordic #(
  parameter int Stages  = aar_pkg::CordicStagesDef,
  parameter int SideW   = 48
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [aar_pkg::FieldW-1:0]           angle_i,
  input  logic [SideW-1:0]                     side_i,
  output logic                                 valid_o,
  output logic                                 flip_o,
  output logic signed [aar_pkg::CordicW-1:0]   x_o,
  output logic signed [aar_pkg::CordicW-1:0]   y_o,
  output logic [SideW-1:0]                     side_o
);
  localparam int N  = (Stages < aar_pkg::TableLen) ? Stages : aar_pkg::TableLen;
  localparam int W  = aar_pkg::CordicW;
  localparam int ZW = aar_pkg::AngleW + 1;

  logic                 v_q    [N+1];
  logic                 f_q    [N+1];
  logic signed [W-1:0]  x_q    [N+1];
  logic signed [W-1:0]  y_q    [N+1];
  logic signed [ZW-1:0] z_q    [N+1];
  logic [SideW-1:0]     s_q    [N+1];

  logic [aar_pkg::AngleW-1:0] p0;
  logic [1:0]                 quad;
  logic [aar_pkg::AngleW-1:0] p1;

  always_comb begin
    p0   = {angle_i, {(aar_pkg::AngleW - aar_pkg::FieldW){1'b0}}};
    quad = p0[aar_pkg::AngleW-1 -: 2];
    p1   = (quad == 2'b01 || quad == 2'b10) ? (p0 ^ {1'b1, {(aar_pkg::AngleW-1){1'b0}}}) : p0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q[0] <= (quad == 2'b01 || quad == 2'b10);
      x_q[0] <= aar_pkg::InvGain;
      y_q[0] <= '0;
      z_q[0] <= {p1[aar_pkg::AngleW-1], p1};
      s_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [W-1:0]  dx, dy;
    logic signed [ZW-1:0] at;
    assign dx = x_q[i] >>> i;
    assign dy = y_q[i] >>> i;
    assign at = aar_pkg::atan_turn(i);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        f_q[i+1] <= f_q[i];
        s_q[i+1] <= s_q[i];
        if (!z_q[i][ZW-1]) begin
          x_q[i+1] <= x_q[i] - dy;
          y_q[i+1] <= y_q[i] + dx;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dy;
          y_q[i+1] <= y_q[i] - dx;
          z_q[i+1] <= z_q[i] + at;
        end
      end
    end
  end

  assign valid_o = v_q[N];
  assign flip_o  = f_q[N];
  assign x_o     = x_q[N];
  assign y_o     = y_q[N];
  assign side_o  = s_q[N];
endmodule

>>> rtl/aar_matrix.sv
// Rodrigues matrix stage: rounds cos/sin, forms products and saturates nine entries.
// Depends on aar_pkg.
module aar_matrix #(
  parameter int FracBits = aar_pkg::FracBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic                               flip_i,
  input  logic signed [aar_pkg::CordicW-1:0] x_i,
  input  logic signed [aar_pkg::CordicW-1:0] y_i,
  input  aar_pkg::field_t                    ax_i,
  input  aar_pkg::field_t                    ay_i,
  input  aar_pkg::field_t                    az_i,
  output logic                               valid_o,
  output aar_pkg::mat_t                      mat_o
);
  localparam int W   = aar_pkg::CordicW + 2;
  localparam int PW  = 2 * aar_pkg::FieldW + 1;
  localparam int EW  = 64;
  localparam int Sh  = aar_pkg::CordicFrac - FracBits;
  // cos, sin and 1-c stay within +-2^(FracBits+1); axis products within 2^(30-FracBits)
  localparam int CsW = FracBits + 3;
  localparam int AaW = 2 * aar_pkg::FieldW + 1 - FracBits;
  localparam int AsW = aar_pkg::FieldW + CsW;
  localparam logic signed [CsW-1:0] One = CsW'(1) <<< FracBits;

  typedef logic signed [W-1:0]   cs_t;
  typedef logic signed [CsW-1:0] csn_t;
  typedef logic signed [AaW-1:0] aa_t;
  typedef logic signed [AsW-1:0] as_t;
  typedef logic signed [EW-1:0]  wide_t;

  // stage A: negate and round cos/sin
  logic  v_a_q;
  csn_t  c_a_q, s_a_q;
  aar_pkg::field_t ax_a_q, ay_a_q, az_a_q;
  cs_t   xf, yf;

  always_comb begin
    xf = flip_i ? -W'(x_i) : W'(x_i);
    yf = flip_i ? -W'(y_i) : W'(y_i);
  end

  // stage B: products a_i*a_j (rounded), a_k*s, c*one
  logic  v_b_q;
  aa_t   aa_b_q [6];   // xx xy xz yy yz zz
  as_t   as_b_q [3];   // x*s y*s z*s
  csn_t  omc_b_q;
  wide_t cd_b_q;

  // stage C: t*(1-c) + extra
  logic  v_c_q;
  wide_t sum_c_q [9];

  function automatic wide_t rnd(input wide_t v, input int n);
    wide_t r;
    begin
      r = v + (wide_t'(1) <<< (n - 1));
      return r >>> n;
    end
  endfunction

  function automatic aar_pkg::field_t sat(input wide_t v);
    aar_pkg::field_t r;
    begin
      if (v > 64'sd32767) r = 16'sh7FFF;
      else if (v < -64'sd32768) r = 16'sh8000;
      else r = v[aar_pkg::FieldW-1:0];
      return r;
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
    end else if (en_i) begin
      v_a_q <= valid_i;
      v_b_q <= v_a_q;
      v_c_q <= v_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_a_q  <= CsW'((Sh > 0) ? ((xf + (W'(1) <<< (Sh - 1))) >>> Sh) : xf);
      s_a_q  <= CsW'((Sh > 0) ? ((yf + (W'(1) <<< (Sh - 1))) >>> Sh) : yf);
      ax_a_q <= ax_i;
      ay_a_q <= ay_i;
      az_a_q <= az_i;

      aa_b_q[0] <= AaW'(rnd(EW'(PW'(ax_a_q * ax_a_q)), FracBits));
      aa_b_q[1] <= AaW'(rnd(EW'(PW'(ax_a_q * ay_a_q)), FracBits));
      aa_b_q[2] <= AaW'(rnd(EW'(PW'(ax_a_q * az_a_q)), FracBits));
      aa_b_q[3] <= AaW'(rnd(EW'(PW'(ay_a_q * ay_a_q)), FracBits));
      aa_b_q[4] <= AaW'(rnd(EW'(PW'(ay_a_q * az_a_q)), FracBits));
      aa_b_q[5] <= AaW'(rnd(EW'(PW'(az_a_q * az_a_q)), FracBits));
      as_b_q[0] <= ax_a_q * s_a_q;
      as_b_q[1] <= ay_a_q * s_a_q;
      as_b_q[2] <= az_a_q * s_a_q;
      omc_b_q   <= One - c_a_q;
      cd_b_q    <= EW'(c_a_q) <<< FracBits;

      sum_c_q[0] <= aa_b_q[0] * omc_b_q + cd_b_q;
      sum_c_q[1] <= aa_b_q[1] * omc_b_q - as_b_q[2];
      sum_c_q[2] <= aa_b_q[2] * omc_b_q + as_b_q[1];
      sum_c_q[3] <= aa_b_q[1] * omc_b_q + as_b_q[2];
      sum_c_q[4] <= aa_b_q[3] * omc_b_q + cd_b_q;
      sum_c_q[5] <= aa_b_q[4] * omc_b_q - as_b_q[0];
      sum_c_q[6] <= aa_b_q[2] * omc_b_q - as_b_q[1];
      sum_c_q[7] <= aa_b_q[4] * omc_b_q + as_b_q[0];
      sum_c_q[8] <= aa_b_q[5] * omc_b_q + cd_b_q;
    end
  end

  always_comb begin
    mat_o.m11 = sat(rnd(sum_c_q[0], FracBits));
    mat_o.m12 = sat(rnd(sum_c_q[1], FracBits));
    mat_o.m13 = sat(rnd(sum_c_q[2], FracBits));
    mat_o.m21 = sat(rnd(sum_c_q[3], FracBits));
    mat_o.m22 = sat(rnd(sum_c_q[4], FracBits));
    mat_o.m23 = sat(rnd(sum_c_q[5], FracBits));
    mat_o.m31 = sat(rnd(sum_c_q[6], FracBits));
    mat_o.m32 = sat(rnd(sum_c_q[7], FracBits));
    mat_o.m33 = sat(rnd(sum_c_q[8], FracBits));
  end

  assign valid_o = v_c_q;
endmodule

>>> rtl/axis_angle_rotation_matrix.sv
// Channel   | Dir | Payload
// req_i     | in  | axis_x, axis_y, axis_z (Q2.14), angle (turn fraction)
// rsp_o     | out | m11..m33 (Q2.14, saturated)
// One request enters every cycle while the skid slot is empty.
// The unrolled CORDIC sets the depth, the matrix stage adds three register stages.
// A stall at rsp_o freezes the whole pipeline once the skid slot holds a result; an output
// skid register keeps rsp_o.ready off any combinational path back to req_i.ready.
// Reset clears all valid bits; no clearing pass.
// Depends on aar_pkg, aar_stream_if, aar_cordic, aar_matrix and the macro header.
`include "axis_angle_rotation_matrix_macros.svh"
module axis_angle_rotation_matrix #(
  parameter int CORDIC_STAGES = aar_pkg::CordicStagesDef,
  parameter int FRAC_BITS     = aar_pkg::FracBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  aar_stream_if.sink   req_i,
  aar_stream_if.source rsp_o
);
  localparam int SideW = 3 * aar_pkg::FieldW;

  aar_pkg::req_t req;
  logic          en;
  logic          cv, mv, flip;
  logic signed [aar_pkg::CordicW-1:0] cx, cy;
  logic [SideW-1:0] side;
  aar_pkg::mat_t    mat;

  logic          out_v_q, skid_v_q;
  aar_pkg::mat_t out_q, skid_q;

  assign req = req_i.data;
  // pipeline advances while the skid slot is empty
  assign en          = !skid_v_q;
  assign req_i.ready = en;

  aar_cordic #(.Stages(CORDIC_STAGES), .SideW(SideW)) u_cordic (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(req_i.valid),
    .angle_i(req.angle),
    .side_i({req.axis_x, req.axis_y, req.axis_z}),
    .valid_o(cv), .flip_o(flip), .x_o(cx), .y_o(cy), .side_o(side)
  );

  aar_matrix #(.FracBits(FRAC_BITS)) u_matrix (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(cv), .flip_i(flip), .x_i(cx), .y_i(cy),
    .ax_i(side[3*aar_pkg::FieldW-1 -: aar_pkg::FieldW]),
    .ay_i(side[2*aar_pkg::FieldW-1 -: aar_pkg::FieldW]),
    .az_i(side[aar_pkg::FieldW-1:0]),
    .valid_o(mv), .mat_o(mat)
  );

  // output register plus skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (skid_v_q) begin
        if (rsp_o.ready) begin
          skid_v_q <= 1'b0;
          out_v_q  <= 1'b1;
        end
      end else if (out_v_q && !rsp_o.ready) begin
        skid_v_q <= mv;
      end else begin
        out_v_q <= mv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (rsp_o.ready) out_q <= skid_q;
    end else if (out_v_q && !rsp_o.ready) begin
      skid_q <= mat;
    end else begin
      out_q <= mat;
    end
  end

  assign rsp_o.valid = out_v_q;
  assign rsp_o.data  = out_q;

  `AAR_ASSERT(a_skid_needs_out, clk_i, rst_ni, skid_v_q |-> out_v_q, "skid full with empty output")
  `AAR_ASSERT(a_no_accept_skid, clk_i, rst_ni, skid_v_q |-> !req_i.ready, "accept while skid full")
  `AAR_ASSERT(a_out_held, clk_i, rst_ni, (out_v_q && !rsp_o.ready) |=> out_v_q, "result dropped")
  `AAR_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |=> (!out_v_q && !skid_v_q), "valid in reset")
endmodule
